// File: sv/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and constants for the LRU block cache
// Entry geometry, operation codes and the cell command and chain link words.
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam int ENTRIES     = 16;
    localparam int BLOCK_BYTES = 8;
    localparam int BLK_W       = 8 * BLOCK_BYTES;
    localparam int RANK_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W       = $clog2(ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int LEN_W       = 4;
    localparam int FILE_W      = 32;
    localparam int OFF_W       = 64;
    localparam int DATA_W      = 64;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    // request function codes
    localparam logic [1:0] FUNC_GET = 2'd0;
    localparam logic [1:0] FUNC_PUT = 2'd1;
    localparam logic [1:0] FUNC_INV = 2'd2;

    // cell update codes
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_PROMOTE = 3'd1;
    localparam logic [2:0] OP_REWRITE = 3'd2;
    localparam logic [2:0] OP_REMOVE  = 3'd3;
    localparam logic [2:0] OP_INSERT  = 3'd4;

    typedef struct packed {
        logic              cmp;
        logic [2:0]        op;
        logic [FILE_W-1:0] file;
        logic [OFF_W-1:0]  off;
        logic [LEN_W-1:0]  slen;
        logic [BLK_W-1:0]  sblock;
        logic [RANK_W-1:0] hit_rank;
        logic [RANK_W-1:0] victim_rank;
        logic              evict;
    } cmd_t;

    typedef struct packed {
        logic              hit_found;
        logic              free_taken;
        logic [RANK_W-1:0] rank;
        logic [LEN_W-1:0]  len;
        logic [BLK_W-1:0]  block;
    } link_t;

    function automatic logic [BLK_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [BLK_W-1:0] m;
        m = '0;
        for (int b = 0; b < BLOCK_BYTES; b++)
        begin
            m[8*b +: 8] = (LEN_W'(b) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// File: sv/lbc_cell.sv
// ----------------------------------------------------------------------------
// lbc_cell: one cache entry
// Holds key, block and recency rank; joins the hit and free-slot chains.
// ----------------------------------------------------------------------------
module lbc_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  lbc_pkg::cmd_t  cmd,
    input  lbc_pkg::link_t link_in,
    output lbc_pkg::link_t link_out
);
    import lbc_pkg::*;

    logic              valid_reg;
    logic              match_reg;
    logic              victim_reg;
    logic [FILE_W-1:0] file_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [BLK_W-1:0]  block_reg;
    logic [RANK_W-1:0] rank_reg;

    logic sel;
    logic free_cand;
    logic take;
    logic gone;

    assign sel       = match_reg & ~link_in.hit_found;
    assign gone      = victim_reg & cmd.evict;
    assign free_cand = ~valid_reg | gone;
    assign take      = free_cand & ~link_in.free_taken;

    always_comb
    begin
        link_out.hit_found  = link_in.hit_found | match_reg;
        link_out.free_taken = link_in.free_taken | free_cand;
        link_out.rank       = sel ? rank_reg  : link_in.rank;
        link_out.len        = sel ? len_reg   : link_in.len;
        link_out.block      = sel ? block_reg : link_in.block;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            match_reg  <= 1'b0;
            victim_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cmp)
            begin
                match_reg  <= valid_reg && file_reg == cmd.file && off_reg == cmd.off;
                victim_reg <= valid_reg && rank_reg == cmd.victim_rank;
            end
            case (cmd.op)
                OP_REMOVE: if (sel) valid_reg <= 1'b0;
                OP_INSERT:
                begin
                    if (take)
                        valid_reg <= 1'b1;
                    else if (gone)
                        valid_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op) inside
            OP_PROMOTE, OP_REWRITE:
            begin
                if (sel)
                begin
                    rank_reg <= '0;
                    if (cmd.op == OP_REWRITE)
                    begin
                        len_reg   <= cmd.slen;
                        block_reg <= cmd.sblock;
                    end
                end
                else if (valid_reg && rank_reg < cmd.hit_rank)
                    rank_reg <= rank_reg + 1'b1;
            end
            OP_REMOVE:
            begin
                if (!sel && valid_reg && rank_reg > cmd.hit_rank)
                    rank_reg <= rank_reg - 1'b1;
            end
            OP_INSERT:
            begin
                if (take)
                begin
                    file_reg  <= cmd.file;
                    off_reg   <= cmd.off;
                    len_reg   <= cmd.slen;
                    block_reg <= cmd.sblock;
                    rank_reg  <= '0;
                end
                else if (valid_reg && !gone)
                    rank_reg <= rank_reg + 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// File: sv/lru_block_cache.sv
// ----------------------------------------------------------------------------
// lru_block_cache: fully associative block cache with LRU replacement
// Top level: request sequencer, cell chain, result register, capacity reg.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (in_valid/in_ready) carries one word: func, file_id,
//   offset, length, write_data. func 0 = get, 1 = put, 2 = invalidate.
//   Response channel (out_valid/out_ready) returns one word per request:
//   status (1 = get miss), read_len, read_data.
//   Config channel (cfg_valid/cfg_ready) writes capacity; always ready.
//   Write it only while no request is in flight.
// Timing
//   Each request passes a compare state, where every cell matches the key
//   in parallel, then an update state, where the hit and free-slot chains
//   pick one cell and the affected ranks move. Result appears the cycle after
//   the update. A new request is taken in the idle state or in the update
//   state of the one before, so two requests never share the cell chain.
// Reset
//   All entries invalid, occupancy 0, capacity 16. No clearing pass.
// Stall
//   The result sits in an output register; while it waits, the update of
//   the request behind it and the intake of the next request both hold off
//   until the register frees up.
// ----------------------------------------------------------------------------
module lru_block_cache (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lbc_pkg::CAP_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                func,
    input  logic [31:0]               file_id,
    input  logic [63:0]               offset,
    input  logic [3:0]                length,
    input  logic [63:0]               write_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      status,
    output logic [3:0]                read_len,
    output logic [63:0]               read_data
);
    import lbc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [1:0]        func_reg;
    logic [FILE_W-1:0] file_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [DATA_W-1:0] wdata_reg;

    logic              out_valid_reg;
    logic              status_reg;
    logic [LEN_W-1:0]  bytes_reg;
    logic [DATA_W-1:0] rdata_reg;

    cmd_t  cmd;
    link_t link [ENTRIES+1];

    logic             accept;
    logic             upd_go;
    logic             get_hit;
    logic             evict;
    logic [OCC_W-1:0] eff_cap;
    logic [LEN_W-1:0] slen;

    assign cfg_ready = 1'b1;
    assign upd_go    = (state_reg == ST_UPD) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == ST_IDLE) || upd_go;
    assign accept    = in_valid && in_ready;

    // capacity clamp: 0 acts as 1, above ENTRIES acts as ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = OCC_W'(1);
        else if (32'(cap_reg) > 32'(ENTRIES))
            eff_cap = OCC_W'(ENTRIES);
        else
            eff_cap = OCC_W'(cap_reg);
    end

    assign evict = (occ_reg >= eff_cap) && (occ_reg != '0);
    assign slen  = (32'(len_reg) > 32'(BLOCK_BYTES)) ? LEN_W'(BLOCK_BYTES) : len_reg;

    // a hit only counts for get
    assign get_hit = (func_reg == FUNC_GET)
                  && link[ENTRIES].hit_found
                  && 32'(len_reg) <= 32'(BLOCK_BYTES)
                  && link[ENTRIES].len >= len_reg;

    always_comb
    begin
        cmd.cmp         = (state_reg == ST_CMP);
        cmd.file        = file_reg;
        cmd.off         = off_reg;
        cmd.slen        = slen;
        cmd.sblock      = wdata_reg[BLK_W-1:0] & byte_mask(slen);
        cmd.hit_rank    = link[ENTRIES].rank;
        cmd.victim_rank = RANK_W'(occ_reg - 1'b1);
        cmd.evict       = evict;
        cmd.op          = OP_NONE;
        if (upd_go)
        begin
            unique case (func_reg)
                FUNC_GET: cmd.op = get_hit ? OP_PROMOTE : OP_NONE;
                FUNC_PUT: cmd.op = link[ENTRIES].hit_found ? OP_REWRITE : OP_INSERT;
                FUNC_INV: cmd.op = link[ENTRIES].hit_found ? OP_REMOVE : OP_NONE;
                default:  cmd.op = OP_NONE;
            endcase
        end
    end

    assign link[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lbc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .link_in  (link[i]),
            .link_out (link[i+1])
        );
    end

    // occupancy follows insert (net of eviction) and remove
    always_comb
    begin
        occ_next = occ_reg;
        case (cmd.op)
            OP_INSERT:
                if (link[ENTRIES].free_taken)
                    occ_next = occ_reg - OCC_W'(evict) + 1'b1;
                else
                    occ_next = occ_reg - OCC_W'(evict);
            OP_REMOVE: occ_next = occ_reg - 1'b1;
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_CMP;
            ST_CMP:  state_next = ST_UPD;
            ST_UPD:  if (upd_go) state_next = accept ? ST_CMP : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAPACITY_RESET;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            if (upd_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            file_reg  <= file_id;
            off_reg   <= offset;
            len_reg   <= length;
            wdata_reg <= write_data;
        end
        if (upd_go)
        begin
            status_reg <= (func_reg == FUNC_GET) && !get_hit;
            bytes_reg  <= get_hit ? len_reg : '0;
            rdata_reg  <= get_hit
                ? DATA_W'(link[ENTRIES].block & byte_mask(len_reg)) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign read_len  = bytes_reg;
    assign read_data = rdata_reg;

endmodule

// File: sv/lbc_checker.sv
// ----------------------------------------------------------------------------
// lbc_checker: port-level checks for the LRU block cache
// Response word consistency and output hold under stall.
// ----------------------------------------------------------------------------
module lbc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        status,
    input logic [3:0]  read_len,
    input logic [63:0] read_data
);
    import lbc_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data)
                                    && $stable(read_len) && $stable(status))
        else $error("response word changed while stalled");

    a_miss_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> read_len == 4'd0 && read_data == 64'd0)
        else $error("miss carries data");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(read_len) <= 32'(BLOCK_BYTES))
        else $error("read_len above block size");

    a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_len < 4'd8 |-> (read_data >> (8 * read_len)) == 64'd0)
        else $error("bytes beyond read_len not zero");

endmodule

bind lru_block_cache lbc_checker u_lbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .read_len  (read_len),
    .read_data (read_data)
);

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for lru_block_cache
// Directed table, then random traffic over a small key pool, checked
// word by word against a behavioral LRU model, under several idling phases.
// ----------------------------------------------------------------------------
module tb_top;
    import lbc_pkg::*;

    // drain pause before config writes
    localparam int DRAIN_CYCLES = 8;
    localparam int WATCHDOG     = 20000;
    localparam int MAX_SHOWN    = 10;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CAP_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        func;
    logic [31:0]       file_id;
    logic [63:0]       offset;
    logic [3:0]        length;
    logic [63:0]       write_data;
    logic              out_valid;
    logic              out_ready;
    logic              status;
    logic [3:0]        read_len;
    logic [63:0]       read_data;

    typedef struct packed {
        logic        status;
        logic [3:0]  nbytes;
        logic [63:0] data;
    } reply_t;

    typedef struct packed {
        logic [1:0]  fn;
        logic [31:0] fid;
        logic [63:0] off;
        logic [3:0]  len;
        logic [63:0] wdata;
        logic        known;   // expected reply typed into the row
        reply_t      reply;
    } row_t;

    lru_block_cache uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .file_id    (file_id),
        .offset     (offset),
        .length     (length),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .read_len   (read_len),
        .read_data  (read_data)
    );

    // ------------------------------------------------------------------
    // Cache model state, mirrors what the block should hold
    // ------------------------------------------------------------------
    logic              m_valid [ENTRIES];
    logic [31:0]       m_file  [ENTRIES];
    logic [63:0]       m_off   [ENTRIES];
    logic [3:0]        m_len   [ENTRIES];
    logic [63:0]       m_block [ENTRIES];
    int unsigned       m_rank  [ENTRIES];
    int unsigned       m_occ;
    logic [CAP_W-1:0]  m_cap;

    reply_t      pending_replies[$];
    int          mismatches;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          recv_hold;     // long receiver stall, own process

    function automatic logic [63:0] keep_bytes(input int unsigned n);
        if (n >= 8)
            return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic int find_entry(input logic [31:0] fid, input logic [63:0] off);
        for (int i = 0; i < ENTRIES; i++)
            if (m_valid[i] && m_file[i] == fid && m_off[i] == off)
                return i;
        return -1;
    endfunction

    task automatic promote(input int slot);
        int unsigned r;
        r = m_rank[slot];
        for (int i = 0; i < ENTRIES; i++)
            if (m_valid[i] && i != slot && m_rank[i] < r)
                m_rank[i]++;
        m_rank[slot] = 0;
    endtask

    task automatic drop_entry(input int slot);
        int unsigned r;
        r = m_rank[slot];
        m_valid[slot] = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            if (m_valid[i] && m_rank[i] > r)
                m_rank[i]--;
        if (m_occ > 0)
            m_occ--;
    endtask

    // Applies one request to the model and returns the reply it produces.
    task automatic cache_access(input row_t rq, output reply_t rp);
        int          slot;
        int          fr;
        int unsigned slen;
        int unsigned cap;
        rp = '0;
        slot = find_entry(rq.fid, rq.off);
        case (rq.fn)
            FUNC_GET:
            begin
                if (slot >= 0 && rq.len <= BLOCK_BYTES && m_len[slot] >= rq.len)
                begin
                    rp.nbytes = rq.len;
                    rp.data = m_block[slot] & keep_bytes(rq.len);
                    promote(slot);
                end
                else
                    rp.status = 1'b1;
            end
            FUNC_PUT:
            begin
                slen = (rq.len > BLOCK_BYTES) ? BLOCK_BYTES : rq.len;
                if (slot < 0)
                begin
                    cap = (m_cap < 1) ? 1 : ((m_cap > ENTRIES) ? ENTRIES : m_cap);
                    if (m_occ >= cap && m_occ > 0)
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (m_valid[i] && m_rank[i] == m_occ - 1)
                            begin
                                drop_entry(i);
                                break;
                            end
                    end
                    fr = -1;
                    for (int i = ENTRIES - 1; i >= 0; i--)
                        if (!m_valid[i])
                            fr = i;
                    if (fr >= 0)
                    begin
                        for (int k = 0; k < ENTRIES; k++)
                            if (m_valid[k])
                                m_rank[k]++;
                        slot = fr;
                        m_valid[slot] = 1'b1;
                        m_file[slot] = rq.fid;
                        m_off[slot] = rq.off;
                        m_rank[slot] = 0;
                        m_occ++;
                    end
                end
                else
                    promote(slot);
                if (slot >= 0)
                begin
                    m_len[slot] = 4'(slen);
                    m_block[slot] = rq.wdata & keep_bytes(slen);
                end
            end
            FUNC_INV:
            begin
                if (slot >= 0)
                    drop_entry(slot);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls plus an optional long hold
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Result check at the rising edge: oldest expectation first.
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("ERROR: unexpected reply word status=%0d bytes=%0d data=%h",
                             status, read_len, read_data);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.status || read_len !== want.nbytes ||
                    read_data !== want.data)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("ERROR: reply exp st=%0d n=%0d d=%h got st=%0d n=%0d d=%h",
                                 want.status, want.nbytes, want.data,
                                 status, read_len, read_data);
                end
            end
        end
    end

    // Watchdog: cycles with no accepted word on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------
    // in_valid stays up after an accept; the next call replaces or drops it, a drain drops it
    task automatic send_request(input row_t rq);
        reply_t rp;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= rq.fn;
        file_id    <= rq.fid;
        offset     <= rq.off;
        length     <= rq.len;
        write_data <= rq.wdata;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        cache_access(rq, rp);
        if (rq.known && rp !== rq.reply)
        begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("ERROR: table row disagrees with model for func %0d", rq.fn);
        end
        pending_replies.push_back(rp);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        m_cap = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random request, mostly over a small key pool so hits and evictions happen.
    function automatic row_t random_request(input bit wide);
        row_t rq;
        rq = '0;
        rq.fn = ($urandom_range(99) < 3) ? 2'd3 :
                (($urandom_range(99) < 45) ? FUNC_GET :
                 (($urandom_range(99) < 75) ? FUNC_PUT : FUNC_INV));
        if (wide)
        begin
            rq.fid = $urandom;
            rq.off = {$urandom, $urandom};
        end
        else
        begin
            rq.fid = $urandom_range(3) ? 32'(5 + $urandom_range(2)) : 32'hFFFF_FFFF;
            rq.off = 64'($urandom_range(7)) << ($urandom_range(1) ? 60 : 3);
        end
        rq.len = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
        rq.wdata = {$urandom, $urandom};
        return rq;
    endfunction

    function automatic row_t mk(input logic [1:0] fn, input logic [31:0] fid,
                                input logic [63:0] off, input logic [3:0] len,
                                input logic [63:0] wd, input logic known,
                                input logic st, input logic [3:0] nb,
                                input logic [63:0] d);
        row_t r;
        r.fn = fn; r.fid = fid; r.off = off; r.len = len; r.wdata = wd;
        r.known = known; r.reply = '{st, nb, d};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        row_t dir_rows[$];
        int   phase_pct[4][2];
        bit   wide;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        func = FUNC_GET;
        file_id = '0;
        offset = '0;
        length = '0;
        write_data = '0;
        recv_hold = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            m_valid[i] = 1'b0;
            m_rank[i] = 0;
        end
        m_occ = 0;
        m_cap = CAPACITY_RESET;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table: empty-cache misses, extremes, odd lengths, func 3
        dir_rows.push_back(mk(FUNC_GET, 0, 0, 0, 0, 1, 1, 0, 0));
        dir_rows.push_back(mk(FUNC_INV, '1, '1, 0, 0, 1, 0, 0, 0));
        dir_rows.push_back(mk(2'd3, '1, '1, 4'hF, '1, 1, 0, 0, 0));
        dir_rows.push_back(mk(FUNC_PUT, '1, '1, 8, '1, 1, 0, 0, 0));
        dir_rows.push_back(mk(FUNC_GET, '1, '1, 8, 0, 1, 0, 8, '1));
        dir_rows.push_back(mk(FUNC_GET, '1, '1, 9, 0, 1, 1, 0, 0));
        dir_rows.push_back(mk(FUNC_GET, '1, '1, 0, 0, 1, 0, 0, 0));
        dir_rows.push_back(mk(FUNC_PUT, 0, 0, 4'hF, 64'h0123_4567_89AB_CDEF, 0, 0, 0, 0));
        dir_rows.push_back(mk(FUNC_GET, 0, 0, 8, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(FUNC_PUT, 1, 2, 3, 64'hAAAA_5555_AAAA_5555, 0, 0, 0, 0));
        dir_rows.push_back(mk(FUNC_GET, 1, 2, 4, 0, 1, 1, 0, 0));
        dir_rows.push_back(mk(FUNC_GET, 1, 2, 2, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(FUNC_PUT, 1, 2, 0, '1, 0, 0, 0, 0));
        dir_rows.push_back(mk(FUNC_GET, 1, 2, 1, 0, 1, 1, 0, 0));
        dir_rows.push_back(mk(FUNC_INV, 1, 2, 0, 0, 1, 0, 0, 0));
        dir_rows.push_back(mk(FUNC_GET, 1, 2, 0, 0, 1, 1, 0, 0));
        dir_rows.push_back(mk(FUNC_INV, 0, 0, 0, 0, 1, 0, 0, 0));
        dir_rows.push_back(mk(FUNC_INV, '1, '1, 0, 0, 1, 0, 0, 0));
        dir_rows.push_back(mk(FUNC_GET, '1, '1, 0, 0, 1, 1, 0, 0));
        foreach (dir_rows[i])
            send_request(dir_rows[i]);

        // capacity 1: each new key after the first evicts the only entry
        write_capacity(5'd1);
        send_request(mk(FUNC_PUT, 7, 7, 8, 64'h11, 0, 0, 0, 0));
        send_request(mk(FUNC_PUT, 8, 8, 8, 64'h22, 0, 0, 0, 0));
        send_request(mk(FUNC_GET, 7, 7, 1, 0, 0, 0, 0, 0));
        send_request(mk(FUNC_GET, 8, 8, 1, 0, 0, 0, 0, 0));

        // idling phases: none, sender, receiver, both
        phase_pct = '{'{0, 0}, '{72, 0}, '{0, 72}, '{29, 29}};
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: write_capacity(5'd16);
                1: write_capacity(5'd0);    // acts as 1
                2: write_capacity(5'd31);   // acts as 16
                3: write_capacity(5'd4);
                4: write_capacity(5'd2);    // below occupancy
                5: write_capacity(5'd8);
                6: write_capacity(5'd17);
                default: write_capacity(5'd3);
            endcase
            send_idle_pct = phase_pct[p % 4][0];
            recv_idle_pct = phase_pct[p % 4][1];
            if (p == 5)
            begin
                // long receiver hold while the sender keeps offering words
                fork
                    begin
                        recv_hold = 1'b1;
                        repeat (200) @(negedge clk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 235; n++)
            begin
                wide = ($urandom_range(19) == 0);
                send_request(random_request(wide));
                if (n == 120)
                    wait_drained();   // sender pause until all replies are in
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
